// ===== rtl/amb_pkg.sv =====
// Package for the arcade drive mixer with proportional braking.
// Holds widths, fixed-point constants, register codes and the divider stage type.
// No dependencies; imported by amb_div, arcade_mix_brake_duty and the testbench.
`default_nettype none

package amb_pkg;

   // Fixed-point constants, Q1.14.
   localparam logic [14:0] Q_ONE           = 15'd16384;
   localparam logic [14:0] BRAKE_THRESHOLD = 15'd491;

   // Divider geometry: 15 quotient bits, three per pipeline stage.
   localparam int QUO_W      = 15;
   localparam int DIV_DEN_W  = 15;
   localparam int DIV_NUM_W  = 34;
   localparam int DIV_STEPS  = 3;
   localparam int DIV_STAGES = QUO_W / DIV_STEPS;

   // Cycles from the accepting edge to the edge that takes the result.
   localparam int PIPE_LATENCY = 2 * DIV_STAGES + 4;

   // Register file.
   localparam int CSR_ADDR_W = 3;
   localparam logic [15:0] BRAKE_GAIN_RESET = 16'd4096;
   localparam logic [14:0] MAX_RATE_RESET   = 15'd1000;

   typedef enum logic {
      REG_BRAKE_GAIN = 1'b0,
      REG_MAX_RATE   = 1'b1
   } csr_reg_type;

   // One stage of the restoring divider.
   typedef struct packed {
      logic [DIV_NUM_W-1:0] rem;
      logic [DIV_DEN_W-1:0] den;
      logic [QUO_W-1:0]     quo;
      logic                 sat;
   } div_stage_type;

   // Clamps a widened sum to the range of plus and minus one.
   function automatic logic [15:0] clamp_q1(input logic signed [16:0] v);
      logic [15:0] r;
      if (v > 17'sd16384) begin
         r = 16'd16384;
      end else if (v < -17'sd16384) begin
         r = 16'hC000;
      end else begin
         r = v[15:0];
      end
      return r;
   endfunction

endpackage

`default_nettype wire

// ===== rtl/amb_div.sv =====
// Pipelined restoring divider with a quotient saturated at one in Q1.14.
// Depends on amb_pkg for widths, stage count and the stage type.
// Three quotient bits are resolved in each of DIV_STAGES register stages.
`default_nettype none

module amb_div import amb_pkg::*; (
   input  wire logic                 clock,
   input  wire logic [DIV_NUM_W-1:0] dividend,
   input  wire logic [DIV_DEN_W-1:0] divisor,
   output logic      [QUO_W-1:0]     quotient
);

   div_stage_type entry;
   div_stage_type src      [DIV_STAGES];
   div_stage_type stage_in [DIV_STAGES];
   div_stage_type stage_ff [DIV_STAGES];
   div_stage_type last;

   // A quotient that would not fit in QUO_W bits is flagged up front, so that the
   // remaining steps may assume the remainder stays below the divisor shifted by QUO_W.
   always_comb begin
      entry.rem = dividend;
      entry.den = divisor;
      entry.quo = '0;
      entry.sat = (dividend >= (DIV_NUM_W'(divisor) << QUO_W));
   end

   // Each stage takes the previous stage's registers, the first takes the operands.
   always_comb begin
      src[0] = entry;
      for (int s = 1; s < DIV_STAGES; s++) begin
         src[s] = stage_ff[s-1];
      end
   end

   // Compare-and-subtract steps, most significant quotient bit first.
   always_comb begin
      logic [DIV_NUM_W-1:0] trial;
      trial = '0;
      for (int s = 0; s < DIV_STAGES; s++) begin
         stage_in[s] = src[s];
         for (int k = 0; k < DIV_STEPS; k++) begin
            trial = DIV_NUM_W'(src[s].den) << (QUO_W - 1 - s * DIV_STEPS - k);
            if (stage_in[s].rem >= trial) begin
               stage_in[s].rem = stage_in[s].rem - trial;
               stage_in[s].quo = stage_in[s].quo
                                 | (QUO_W'(1) << (QUO_W - 1 - s * DIV_STEPS - k));
            end
         end
      end
   end

   // Stage registers carry data only; validity is tracked by the caller.
   always_ff @(posedge clock) begin
      for (int s = 0; s < DIV_STAGES; s++) begin
         stage_ff[s] <= stage_in[s];
      end
   end

   // Saturate at one.
   assign last     = stage_ff[DIV_STAGES-1];
   assign quotient = (last.sat || (last.quo > Q_ONE)) ? Q_ONE : last.quo;

endmodule

`default_nettype wire

// ===== rtl/arcade_mix_brake_duty.sv =====
// Arcade drive mixer with proportional braking, top level.
// Depends on amb_pkg and amb_div (two speed dividers, two brake dividers).
//
//   Channel   Ports                                  Transaction
//   command   start, busy, req_*                     start high while busy low
//   result    rsp_valid, rsp_*                       one cycle, rsp_valid high
//   control   psel, penable, pwrite, paddr, pwdata,  write in the access cycle
//             prdata, pready
//
// A new command is taken in every cycle; busy is never raised.
// Each result passes, in order, the input register, the speed divider stages
// (three quotient bits per stage), the brake decision and gain multiply registers,
// the brake divider stages and the output register.
// Synchronous reset clears the valid bits and loads the control registers with their reset values.
// The receiver cannot stall, so nothing in the pipeline ever holds.
`default_nettype none

module arcade_mix_brake_duty import amb_pkg::*; (
   input  wire logic                  clock,
   input  wire logic                  reset,
   // Command channel.
   input  wire logic                  start,
   output logic                       busy,
   input  wire logic signed [15:0]    req_forward_cmd,
   input  wire logic signed [15:0]    req_turn_cmd,
   input  wire logic signed [15:0]    req_left_rate,
   input  wire logic signed [15:0]    req_right_rate,
   // Result channel.
   output logic                       rsp_valid,
   output logic signed [15:0]         rsp_left_drive,
   output logic signed [15:0]         rsp_right_drive,
   output logic        [14:0]         rsp_left_brake,
   output logic        [14:0]         rsp_right_brake,
   // Control port.
   input  wire logic                  psel,
   input  wire logic                  penable,
   input  wire logic                  pwrite,
   input  wire logic [CSR_ADDR_W-1:0] paddr,
   input  wire logic [31:0]           pwdata,
   output logic      [31:0]           prdata,
   output logic                       pready
);

   // Control registers.
   logic [15:0] brake_gain_ff;
   logic [14:0] max_rate_ff;
   logic        csr_write;
   logic [14:0] rate_div;

   // Input stage.
   logic        a_vld_ff;
   logic [15:0] a_drv_in [2];
   logic [15:0] a_mag_in [2];
   logic        a_neg_in [2];
   logic [15:0] a_drv_ff [2];
   logic [15:0] a_mag_ff [2];
   logic        a_neg_ff [2];
   logic signed [16:0] lsum;
   logic signed [16:0] rsum;

   // Alongside the speed dividers.
   logic [DIV_STAGES-1:0] vld1_ff;
   logic [15:0]           drv1_ff [DIV_STAGES][2];
   logic                  neg1_ff [DIV_STAGES][2];
   logic [QUO_W-1:0]      spd_q   [2];

   // Brake decision stage.
   logic        c_vld_ff;
   logic        c_brk_in  [2];
   logic [15:0] c_diff_in [2];
   logic        c_brk_ff  [2];
   logic [15:0] c_diff_ff [2];
   logic [14:0] c_as_ff   [2];
   logic [15:0] c_drv_ff  [2];

   // Gain multiply stage.
   logic        d_vld_ff;
   logic [31:0] d_num_in [2];
   logic [31:0] d_num_ff [2];
   logic [14:0] d_as_ff  [2];
   logic        d_brk_ff [2];
   logic [15:0] d_drv_ff [2];

   // Alongside the brake dividers.
   logic [DIV_STAGES-1:0] vld2_ff;
   logic                  brk2_ff [DIV_STAGES][2];
   logic [15:0]           drv2_ff [DIV_STAGES][2];
   logic [QUO_W-1:0]      brk_q   [2];

   // Output registers.
   logic        rsp_valid_ff;
   logic [15:0] rsp_drv_in   [2];
   logic [14:0] rsp_brk_in   [2];
   logic [15:0] rsp_drv_ff   [2];
   logic [14:0] rsp_brk_ff   [2];

   // ------------------------------------------------------------------
   // Control port: always ready, writes land in the access cycle.
   assign pready    = 1'b1;
   assign csr_write = psel && penable && pwrite && pready;

   always_ff @(posedge clock) begin
      if (reset) begin
         brake_gain_ff <= BRAKE_GAIN_RESET;
         max_rate_ff   <= MAX_RATE_RESET;
      end else if (csr_write) begin
         case (csr_reg_type'(paddr[2]))
            REG_BRAKE_GAIN: brake_gain_ff <= pwdata[15:0];
            REG_MAX_RATE:   max_rate_ff   <= pwdata[14:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      case (csr_reg_type'(paddr[2]))
         REG_BRAKE_GAIN: prdata = {16'd0, brake_gain_ff};
         REG_MAX_RATE:   prdata = {17'd0, max_rate_ff};
         default:        prdata = '0;
      endcase
   end

   // A zero full-scale rate is treated as one.
   assign rate_div = (max_rate_ff == 15'd0) ? 15'd1 : max_rate_ff;

   // ------------------------------------------------------------------
   // Input stage: mix and clamp the drives, split the rates into magnitude and sign.
   assign busy = 1'b0;
   assign lsum = $signed({req_forward_cmd[15], req_forward_cmd})
               + $signed({req_turn_cmd[15], req_turn_cmd});
   assign rsum = $signed({req_forward_cmd[15], req_forward_cmd})
               - $signed({req_turn_cmd[15], req_turn_cmd});

   always_comb begin
      a_drv_in[0] = clamp_q1(lsum);
      a_drv_in[1] = clamp_q1(rsum);
      a_neg_in[0] = req_left_rate[15];
      a_neg_in[1] = req_right_rate[15];
      a_mag_in[0] = req_left_rate[15]  ? 16'(-req_left_rate)  : req_left_rate;
      a_mag_in[1] = req_right_rate[15] ? 16'(-req_right_rate) : req_right_rate;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         a_vld_ff <= 1'b0;
      end else begin
         a_vld_ff <= start && !busy;
      end
   end

   always_ff @(posedge clock) begin
      for (int i = 0; i < 2; i++) begin
         a_drv_ff[i] <= a_drv_in[i];
         a_mag_ff[i] <= a_mag_in[i];
         a_neg_ff[i] <= a_neg_in[i];
      end
   end

   // ------------------------------------------------------------------
   // Speed and brake dividers, one pair per side.
   for (genvar g = 0; g < 2; g++) begin : g_side
      amb_div u_speed_div (
         .clock    (clock),
         .dividend (DIV_NUM_W'({a_mag_ff[g], 14'd0})),
         .divisor  (rate_div),
         .quotient (spd_q[g])
      );

      amb_div u_brake_div (
         .clock    (clock),
         .dividend (DIV_NUM_W'({d_num_ff[g], 2'b00})),
         .divisor  (d_as_ff[g]),
         .quotient (brk_q[g])
      );
   end

   // Drive and rate sign travel alongside the speed dividers.
   always_ff @(posedge clock) begin
      if (reset) begin
         vld1_ff <= '0;
      end else begin
         vld1_ff <= {vld1_ff[DIV_STAGES-2:0], a_vld_ff};
      end
   end

   always_ff @(posedge clock) begin
      for (int i = 0; i < 2; i++) begin
         drv1_ff[0][i] <= a_drv_ff[i];
         neg1_ff[0][i] <= a_neg_ff[i];
         for (int s = 1; s < DIV_STAGES; s++) begin
            drv1_ff[s][i] <= drv1_ff[s-1][i];
            neg1_ff[s][i] <= neg1_ff[s-1][i];
         end
      end
   end

   // ------------------------------------------------------------------
   // Brake decision: above the threshold, and faster than or opposed to the drive.
   always_comb begin
      logic [14:0]        q;
      logic               neg;
      logic [15:0]        drv;
      logic [15:0]        ndrv;
      logic [14:0]        absdrv;
      logic signed [16:0] speed;
      logic signed [16:0] diff;
      logic [16:0]        ndiff;
      logic               sp_pos, sp_neg, dr_pos, dr_neg;
      for (int i = 0; i < 2; i++) begin
         q      = spd_q[i];
         neg    = neg1_ff[DIV_STAGES-1][i];
         drv    = drv1_ff[DIV_STAGES-1][i];
         ndrv   = -drv;
         absdrv = drv[15] ? ndrv[14:0] : drv[14:0];
         speed  = neg ? -$signed({2'b00, q}) : $signed({2'b00, q});
         diff   = speed - $signed({drv[15], drv});
         ndiff  = -diff;
         sp_pos = (q != 15'd0) && !neg;
         sp_neg = (q != 15'd0) && neg;
         dr_pos = (drv != 16'd0) && !drv[15];
         dr_neg = drv[15];
         c_diff_in[i] = diff[16] ? ndiff[15:0] : diff[15:0];
         c_brk_in[i]  = (q > BRAKE_THRESHOLD)
                        && ((q > absdrv) || (sp_pos != dr_pos) || (sp_neg != dr_neg));
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         c_vld_ff <= 1'b0;
      end else begin
         c_vld_ff <= vld1_ff[DIV_STAGES-1];
      end
   end

   always_ff @(posedge clock) begin
      for (int i = 0; i < 2; i++) begin
         c_brk_ff[i]  <= c_brk_in[i];
         c_diff_ff[i] <= c_diff_in[i];
         c_as_ff[i]   <= spd_q[i];
         c_drv_ff[i]  <= drv1_ff[DIV_STAGES-1][i];
      end
   end

   // ------------------------------------------------------------------
   // Gain times speed error; the factor of four is applied at the divider input.
   always_comb begin
      for (int i = 0; i < 2; i++) begin
         d_num_in[i] = brake_gain_ff * c_diff_ff[i];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         d_vld_ff <= 1'b0;
      end else begin
         d_vld_ff <= c_vld_ff;
      end
   end

   always_ff @(posedge clock) begin
      for (int i = 0; i < 2; i++) begin
         d_num_ff[i] <= d_num_in[i];
         d_as_ff[i]  <= c_as_ff[i];
         d_brk_ff[i] <= c_brk_ff[i];
         d_drv_ff[i] <= c_drv_ff[i];
      end
   end

   // Brake flag and drive travel alongside the brake dividers.
   always_ff @(posedge clock) begin
      if (reset) begin
         vld2_ff <= '0;
      end else begin
         vld2_ff <= {vld2_ff[DIV_STAGES-2:0], d_vld_ff};
      end
   end

   always_ff @(posedge clock) begin
      for (int i = 0; i < 2; i++) begin
         brk2_ff[0][i] <= d_brk_ff[i];
         drv2_ff[0][i] <= d_drv_ff[i];
         for (int s = 1; s < DIV_STAGES; s++) begin
            brk2_ff[s][i] <= brk2_ff[s-1][i];
            drv2_ff[s][i] <= drv2_ff[s-1][i];
         end
      end
   end

   // ------------------------------------------------------------------
   // Output stage: a braking side gets its duty and loses its drive.
   always_comb begin
      for (int i = 0; i < 2; i++) begin
         rsp_drv_in[i] = brk2_ff[DIV_STAGES-1][i] ? 16'd0 : drv2_ff[DIV_STAGES-1][i];
         rsp_brk_in[i] = brk2_ff[DIV_STAGES-1][i] ? brk_q[i] : 15'd0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= vld2_ff[DIV_STAGES-1];
      end
   end

   always_ff @(posedge clock) begin
      for (int i = 0; i < 2; i++) begin
         rsp_drv_ff[i] <= rsp_drv_in[i];
         rsp_brk_ff[i] <= rsp_brk_in[i];
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_left_drive  = rsp_drv_ff[0];
   assign rsp_right_drive = rsp_drv_ff[1];
   assign rsp_left_brake  = rsp_brk_ff[0];
   assign rsp_right_brake = rsp_brk_ff[1];

   // ------------------------------------------------------------------
   // Checks on the pipeline.

   // A result leaves exactly the pipeline depth after its command entered.
   a_latency: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(start, PIPE_LATENCY))
      else $error("result without a command at the expected depth");

   // A side never drives and brakes at once.
   a_brake_excl: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !(rsp_left_brake != 15'd0 && rsp_left_drive != 16'sd0)
                 && !(rsp_right_brake != 15'd0 && rsp_right_drive != 16'sd0))
      else $error("drive and brake both active on one side");

   // Brake duty saturates at one.
   a_brake_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_left_brake <= Q_ONE && rsp_right_brake <= Q_ONE)
      else $error("brake duty above one");

   // Drives stay within plus and minus one.
   a_drive_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_left_drive <= 16'sd16384 && rsp_left_drive >= -16'sd16384
                 && rsp_right_drive <= 16'sd16384 && rsp_right_drive >= -16'sd16384)
      else $error("drive outside plus and minus one");

endmodule

`default_nettype wire

// ===== dv/testbench.sv =====
// Self-checking testbench for arcade_mix_brake_duty: command and result channels
// plus the control port. It predicts every result in a small scoreboard class.
// Depends on amb_pkg and on the RTL of arcade_mix_brake_duty and its dividers.

// Expected contents of one result transaction.
typedef struct {
   logic signed [15:0] left_drive;
   logic signed [15:0] right_drive;
   logic        [14:0] left_brake;
   logic        [14:0] right_brake;
} mix_output_type;

class mix_scoreboard;
   mix_output_type pending_outputs[$];
   logic [15:0] gain;
   logic [14:0] full_rate;
   int          error_count;

   function new();
      gain        = amb_pkg::BRAKE_GAIN_RESET;
      full_rate   = amb_pkg::MAX_RATE_RESET;
      error_count = 0;
   endfunction

   function void set_register(amb_pkg::csr_reg_type which, logic [31:0] value);
      case (which)
         amb_pkg::REG_BRAKE_GAIN: gain = value[15:0];
         amb_pkg::REG_MAX_RATE: full_rate = value[14:0];
         default: ;
      endcase
   endfunction

   function logic [31:0] register_value(amb_pkg::csr_reg_type which);
      if (which == amb_pkg::REG_BRAKE_GAIN) begin
         return {16'd0, gain};
      end
      return {17'd0, full_rate};
   endfunction

   function int magnitude(int v);
      return (v < 0) ? -v : v;
   endfunction

   function int signum(int v);
      return (v > 0) ? 1 : ((v < 0) ? -1 : 0);
   endfunction

   function int clamp_unit(int v);
      if (v > int'(amb_pkg::Q_ONE)) begin
         return int'(amb_pkg::Q_ONE);
      end else if (v < -int'(amb_pkg::Q_ONE)) begin
         return -int'(amb_pkg::Q_ONE);
      end
      return v;
   endfunction

   // Encoder rate to Q1.14 speed; the quotient truncates on the magnitude.
   function int scaled_speed(logic signed [15:0] rate);
      int     mag;
      longint divisor;
      longint q;
      divisor = (full_rate == 15'd0) ? 64'd1 : longint'(full_rate);
      mag     = magnitude(int'(rate));
      q       = longint'(mag) * longint'(amb_pkg::Q_ONE) / divisor;
      if (q > longint'(amb_pkg::Q_ONE)) begin
         q = longint'(amb_pkg::Q_ONE);
      end
      return (rate < 0) ? -int'(q) : int'(q);
   endfunction

   // Above the threshold, a side brakes if faster than commanded or against the command.
   function bit wants_brake(int speed, int drive);
      if (magnitude(speed) <= int'(amb_pkg::BRAKE_THRESHOLD)) begin
         return 1'b0;
      end
      return (magnitude(speed) > magnitude(drive)) || (signum(speed) != signum(drive));
   endfunction

   function logic [14:0] brake_duty(int speed, int drive);
      longint num;
      longint q;
      num = longint'(gain) * longint'(magnitude(speed - drive)) * 64'd4;
      q   = num / longint'(magnitude(speed));
      if (q > longint'(amb_pkg::Q_ONE)) begin
         q = longint'(amb_pkg::Q_ONE);
      end
      return q[14:0];
   endfunction

   // Works out the result of an accepted command and queues it.
   function void note_command(logic signed [15:0] fwd, logic signed [15:0] turn,
                              logic signed [15:0] lrate, logic signed [15:0] rrate);
      mix_output_type outp;
      int          ldrive;
      int          rdrive;
      int          lspeed;
      int          rspeed;
      ldrive          = clamp_unit(int'(fwd) + int'(turn));
      rdrive          = clamp_unit(int'(fwd) - int'(turn));
      lspeed          = scaled_speed(lrate);
      rspeed          = scaled_speed(rrate);
      outp.left_brake  = 15'd0;
      outp.right_brake = 15'd0;
      if (wants_brake(lspeed, ldrive)) begin
         outp.left_brake = brake_duty(lspeed, ldrive);
         ldrive          = 0;
      end
      if (wants_brake(rspeed, rdrive)) begin
         outp.right_brake = brake_duty(rspeed, rdrive);
         rdrive           = 0;
      end
      outp.left_drive  = 16'(ldrive);
      outp.right_drive = 16'(rdrive);
      pending_outputs.push_back(outp);
   endfunction

   // Compares one result transaction with the oldest prediction.
   function void check_output(logic signed [15:0] ldrive, logic signed [15:0] rdrive,
                              logic [14:0] lbrake, logic [14:0] rbrake);
      mix_output_type outp;
      if (pending_outputs.size() == 0) begin
         $error("result transaction with no command outstanding");
         error_count++;
         return;
      end
      outp = pending_outputs.pop_front();
      if (ldrive !== outp.left_drive) begin
         $error("left_drive: expected %0d, got %0d", outp.left_drive, ldrive);
         error_count++;
      end
      if (rdrive !== outp.right_drive) begin
         $error("right_drive: expected %0d, got %0d", outp.right_drive, rdrive);
         error_count++;
      end
      if (lbrake !== outp.left_brake) begin
         $error("left_brake: expected %0d, got %0d", outp.left_brake, lbrake);
         error_count++;
      end
      if (rbrake !== outp.right_brake) begin
         $error("right_brake: expected %0d, got %0d", outp.right_brake, rbrake);
         error_count++;
      end
   endfunction
endclass

module testbench import amb_pkg::*; ();
   timeunit 1ns;
   timeprecision 1ps;

   localparam int SEGMENTS      = 6;
   localparam int SEGMENT_ITEMS = 325;

   logic                    clock = 1'b0;
   logic                    reset = 1'b1;
   logic                    start = 1'b0;
   logic                    busy;
   logic signed [15:0]      req_forward_cmd = '0;
   logic signed [15:0]      req_turn_cmd = '0;
   logic signed [15:0]      req_left_rate = '0;
   logic signed [15:0]      req_right_rate = '0;
   logic                    rsp_valid;
   logic signed [15:0]      rsp_left_drive;
   logic signed [15:0]      rsp_right_drive;
   logic        [14:0]      rsp_left_brake;
   logic        [14:0]      rsp_right_brake;
   logic                    psel = 1'b0;
   logic                    penable = 1'b0;
   logic                    pwrite = 1'b0;
   logic [CSR_ADDR_W-1:0]   paddr = '0;
   logic [31:0]             pwdata = '0;
   logic [31:0]             prdata;
   logic                    pready;

   mix_scoreboard chk = new();

   arcade_mix_brake_duty dut (
      .clock(clock), .reset(reset),
      .start(start), .busy(busy),
      .req_forward_cmd(req_forward_cmd), .req_turn_cmd(req_turn_cmd),
      .req_left_rate(req_left_rate), .req_right_rate(req_right_rate),
      .rsp_valid(rsp_valid),
      .rsp_left_drive(rsp_left_drive), .rsp_right_drive(rsp_right_drive),
      .rsp_left_brake(rsp_left_brake), .rsp_right_brake(rsp_right_brake),
      .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
      .pwdata(pwdata), .prdata(prdata), .pready(pready)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   // Generous upper bound on the whole run.
   initial begin
      #2_000_000;
      $display("FAIL");
      $finish;
   end

   // Every result transaction is checked at the edge that takes it.
   always @(posedge clock) begin
      if (!reset && rsp_valid) begin
         chk.check_output(rsp_left_drive, rsp_right_drive, rsp_left_brake, rsp_right_brake);
      end
   end

   // Called at a falling edge; returns at the falling edge after acceptance.
   task automatic send_command(input logic signed [15:0] fwd, input logic signed [15:0] turn,
                               input logic signed [15:0] lrate,
                               input logic signed [15:0] rrate, input int gap_pct);
      bit taken;
      while ($urandom_range(0, 99) < gap_pct) begin
         start           <= 1'b0;
         req_forward_cmd <= 16'($urandom());
         req_turn_cmd    <= 16'($urandom());
         req_left_rate   <= 16'($urandom());
         req_right_rate  <= 16'($urandom());
         @(negedge clock);
      end
      start           <= 1'b1;
      req_forward_cmd <= fwd;
      req_turn_cmd    <= turn;
      req_left_rate   <= lrate;
      req_right_rate  <= rrate;
      taken = 1'b0;
      while (!taken) begin
         @(posedge clock);
         taken = !busy;
         if (taken) begin
            chk.note_command(fwd, turn, lrate, rrate);
         end
         @(negedge clock);
      end
   endtask

   // Write transaction followed by a read-back; leaves the port idle on return.
   task automatic write_register(input csr_reg_type which, input logic [31:0] value);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b1;
      paddr   <= CSR_ADDR_W'(int'(which) * 4);
      pwdata  <= value;
      @(negedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (!pready);
      chk.set_register(which, value);
      @(negedge clock);
      penable <= 1'b0;
      pwrite  <= 1'b0;
      @(negedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (!pready);
      if (prdata !== chk.register_value(which)) begin
         $error("%s: expected %0d, got %0d", which.name(), chk.register_value(which), prdata);
         chk.error_count++;
      end
      @(negedge clock);
      psel    <= 1'b0;
      penable <= 1'b0;
      @(negedge clock);
   endtask

   task automatic wait_drained();
      start <= 1'b0;
      while (chk.pending_outputs.size() != 0) @(negedge clock);
   endtask

   // Mostly in-range commands, with the clamp edges and raw bit patterns mixed in.
   function automatic logic signed [15:0] random_command();
      int v;
      case ($urandom_range(0, 9))
         0, 1, 2, 3, 4, 5: begin
            v = $urandom_range(0, 32768);
            v = v - 16384;
         end
         6: v = $urandom_range(0, 1) ? 16384 : -16384;
         7: begin
            v = $urandom_range(0, 3);
            v = 16384 - v;
            if ($urandom_range(0, 1)) v = -v;
         end
         default: v = $urandom();
      endcase
      return 16'(v);
   endfunction

   // Rates are spread over the configured full scale, with many near the brake threshold.
   function automatic logic signed [15:0] random_rate(input int full);
      int mr;
      int v;
      int thr;
      mr = (full == 0) ? 1 : full;
      case ($urandom_range(0, 9))
         0, 1: return 16'($urandom());
         2, 3, 4, 5, 6: begin
            v = $urandom_range(0, mr + mr / 8);
            if (v > 32767) v = 32767;
         end
         7, 8: begin
            thr = (492 * mr + 16383) / 16384;
            v   = $urandom_range(0, 4);
            v   = thr + v - 2;
            if (v < 0) v = 0;
         end
         default: v = $urandom_range(0, mr / 32 + 1);
      endcase
      if ($urandom_range(0, 1)) v = -v;
      return 16'(v);
   endfunction

   initial begin
      int seg_gain[SEGMENTS];
      int seg_rate[SEGMENTS];
      int gap;

      repeat (4) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // Directed commands under the reset settings (unit gain, full scale 1000).
      send_command(16'sd0, 16'sd0, 16'sd0, 16'sd0, 0);
      send_command(16'sd16384, 16'sd16384, 16'sd0, 16'sd0, 0);
      send_command(-16'sd16384, 16'sd16384, 16'sd0, 16'sd0, 0);
      send_command(-16'sd16384, -16'sd16384, 16'sd0, 16'sd0, 0);
      send_command(16'sh7FFF, 16'sh7FFF, 16'sd0, 16'sd0, 0);
      send_command(16'sh8000, 16'sh8000, 16'sd0, 16'sd0, 0);
      send_command(16'sh8000, 16'sh7FFF, 16'sd0, 16'sd0, 0);
      // Saturated speeds against a zero command, both directions.
      send_command(16'sd0, 16'sd0, 16'sh7FFF, 16'sh8000, 0);
      // Just under and just over the brake threshold, both signs.
      send_command(16'sd0, 16'sd0, 16'sd30, -16'sd30, 0);
      send_command(16'sd0, 16'sd0, 16'sd31, -16'sd31, 0);
      // Same sign: drive ahead of speed, then speed ahead of drive.
      send_command(16'sd8192, 16'sd0, 16'sd100, 16'sd600, 0);
      // Speed against the command, and equal magnitudes of either sign.
      send_command(-16'sd4096, 16'sd0, 16'sd500, -16'sd500, 0);
      send_command(16'sd8192, 16'sd0, 16'sd500, -16'sd500, 0);
      // Turning: one side follows, the other runs faster than its command.
      send_command(16'sd4096, 16'sd8192, 16'sd750, -16'sd750, 0);
      send_command(16'sd0, 16'sd0, 16'sd1, -16'sd1, 0);
      send_command(16'sd16384, -16'sd16384, -16'sd1000, 16'sd1000, 0);
      send_command(-16'sd16384, 16'sd0, -16'sd2000, 16'sd2000, 0);
      send_command(16'sd100, -16'sd100, 16'sd32, 16'sd32, 0);

      // Settings per segment, the extremes of both registers among them.
      seg_gain = '{4096, 0, 65535, 0, 1, 0};
      seg_rate = '{1000, 1, 32767, 0, 0, 0};
      seg_gain[3] = $urandom_range(0, 65535);
      seg_gain[5] = $urandom_range(0, 65535);
      seg_rate[4] = $urandom_range(1, 32767);
      seg_rate[5] = $urandom_range(1, 300);

      for (int s = 0; s < SEGMENTS; s++) begin
         wait_drained();
         write_register(REG_BRAKE_GAIN, 32'(seg_gain[s]));
         write_register(REG_MAX_RATE, 32'(seg_rate[s]));
         // Sender idles often, then very often, then not at all.
         gap = (s < 2) ? 38 : ((s < 4) ? 79 : 0);
         for (int i = 0; i < SEGMENT_ITEMS; i++) begin
            send_command(random_command(), random_command(),
                         random_rate(seg_rate[s]), random_rate(seg_rate[s]), gap);
         end
      end

      wait_drained();
      repeat (PIPE_LATENCY + 4) @(posedge clock);
      if (chk.error_count == 0) begin
         $display("PASS");
      end else begin
         $display("FAIL");
      end
      $finish;
   end
endmodule
